// ----- hw/rtl/tvg_pkg.sv -----
`default_nettype none
package tvg_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int MAX_SEGMENTS = 256;
	localparam int IDX_W        = 9;
	localparam int SEG_W        = 9;
	localparam int RAD_W        = 16;
	localparam int VIDX_W       = 17;
	localparam int DIV_STEPS    = IDX_W + ANGLE_BITS;
	localparam int CORDIC_STEPS = 16;
	localparam int CW           = 32;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

	// arctangent of 2^-i in 2^-32 turns
	localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10680350, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861
	};

	typedef enum logic [1:0] {
		REG_INNER_RADIUS,
		REG_OUTER_RADIUS,
		REG_SIDE_SEGMENTS,
		REG_RING_SEGMENTS
	} reg_index_t;

	typedef struct packed {
		logic [VIDX_W-1:0] vidx;
		logic              quad;
	} meta_t;

	typedef struct packed {
		logic [IDX_W-1:0]      num;
		logic [SEG_W-1:0]      rem;
		logic [ANGLE_BITS-1:0] q;
	} div_lane_t;

	typedef struct packed {
		div_lane_t ring;
		div_lane_t side;
		meta_t     meta;
	} div_t;

	typedef struct packed {
		logic [1:0]            quad;
		logic signed [CW-1:0]  x;
		logic signed [CW-1:0]  y;
		logic signed [CW-1:0]  z;
	} cord_lane_t;

	typedef struct packed {
		cord_lane_t psi;
		cord_lane_t phi;
		meta_t      meta;
	} cord_t;

	function automatic logic [SEG_W-1:0] eff_segments(input logic [SEG_W-1:0] v);
		if (v == '0) begin
			return SEG_W'(1);
		end else if (v > SEG_W'(MAX_SEGMENTS)) begin
			return SEG_W'(MAX_SEGMENTS);
		end
		return v;
	endfunction

	function automatic cord_lane_t cord_init(input logic [ANGLE_BITS-1:0] a);
		cord_lane_t r;
		r.quad = a[ANGLE_BITS-1 -: 2];
		r.z    = signed'({2'b00, a[ANGLE_BITS-3:0], {(CW-ANGLE_BITS){1'b0}}});
		r.x    = CORDIC_GAIN;
		r.y    = '0;
		return r;
	endfunction

	// round half up to Q1.14 and clamp to +-1.0
	function automatic logic signed [15:0] q14_of(input logic signed [CW-1:0] v);
		logic signed [CW:0] r;
		r = (CW+1)'(v) + 33'sd32768;
		r = r >>> 16;
		if (r > 33'sd16384) begin
			return 16'sd16384;
		end else if (r < -33'sd16384) begin
			return -16'sd16384;
		end
		return signed'(r[15:0]);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/torus_vertex_generator.sv -----
// Torus vertex generator: each transaction on the input channel carries one grid point
// (ring_index, side_index) and yields one vertex on the output channel, in order. One point
// is taken every cycle while the output is not stalled; it passes 25 cells of a bit-serial
// divider that turn each index into an angle (one quotient bit per cell), 16 CORDIC rotation
// cells that give sine and cosine of both angles, and 4 stages of multiply, round and saturate.
// The user must write registers through wr_en/wr_index/wr_data only while no point is in flight;
// the block does not enforce it. A segment count of 0 acts as 1, counts above 256 act as 256.
`default_nettype none
module torus_vertex_generator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [1:0]                   wr_index,
	input  wire logic [15:0]                  wr_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [8:0]                   ring_index,
	input  wire logic [8:0]                   side_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [17:0]                pos_x,
	output logic signed [17:0]                pos_y,
	output logic signed [17:0]                pos_z,
	output logic signed [15:0]                norm_x,
	output logic signed [15:0]                norm_y,
	output logic signed [15:0]                norm_z,
	output logic [16:0]                       vertex_index,
	output logic                              quad_valid,
	output logic [16:0]                       corner_next_side,
	output logic [16:0]                       corner_diagonal,
	output logic [16:0]                       corner_next_ring
);

	localparam int DS = tvg_pkg::DIV_STEPS;
	localparam int CS = tvg_pkg::CORDIC_STEPS;

	logic [tvg_pkg::RAD_W-1:0] inner_q;
	logic [tvg_pkg::RAD_W-1:0] outer_q;
	logic [tvg_pkg::SEG_W-1:0] side_seg_q;
	logic [tvg_pkg::SEG_W-1:0] ring_seg_q;
	logic [tvg_pkg::SEG_W-1:0] ns;
	logic [tvg_pkg::SEG_W-1:0] nr;
	logic [tvg_pkg::SEG_W:0]   ns_p1;
	logic [18:0]               vprod;
	logic [tvg_pkg::ANGLE_BITS-1:0] phi_angle;

	logic           div_valid [DS+1];
	logic           div_ready [DS+1];
	tvg_pkg::div_t  div_data  [DS+1];
	logic           cord_valid [CS+1];
	logic           cord_ready [CS+1];
	tvg_pkg::cord_t cord_data  [CS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q    <= 16'd256;
			outer_q    <= 16'd512;
			side_seg_q <= 9'd16;
			ring_seg_q <= 9'd16;
		end else if (wr_en) begin
			unique case (tvg_pkg::reg_index_t'(wr_index))
				tvg_pkg::REG_INNER_RADIUS:  inner_q    <= wr_data;
				tvg_pkg::REG_OUTER_RADIUS:  outer_q    <= wr_data;
				tvg_pkg::REG_SIDE_SEGMENTS: side_seg_q <= wr_data[tvg_pkg::SEG_W-1:0];
				tvg_pkg::REG_RING_SEGMENTS: ring_seg_q <= wr_data[tvg_pkg::SEG_W-1:0];
				default: ;
			endcase
		end
	end

	assign ns    = tvg_pkg::eff_segments(side_seg_q);
	assign nr    = tvg_pkg::eff_segments(ring_seg_q);
	assign ns_p1 = {1'b0, ns} + 10'd1;
	assign vprod = 19'(ring_index) * 19'(ns_p1) + 19'(side_index);

	always_comb begin
		div_data[0].ring.num  = ring_index;
		div_data[0].ring.rem  = '0;
		div_data[0].ring.q    = '0;
		div_data[0].side.num  = side_index;
		div_data[0].side.rem  = '0;
		div_data[0].side.q    = '0;
		div_data[0].meta.vidx = vprod[tvg_pkg::VIDX_W-1:0];
		div_data[0].meta.quad = (ring_index < nr) && (side_index < ns);
	end

	assign div_valid[0] = in_valid;
	assign in_ready     = div_ready[0];

	for (genvar i = 0; i < DS; i++) begin : g_div
		tvg_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ring_seg (nr),
			.side_seg (ns),
			.up_valid (div_valid[i]),
			.up_ready (div_ready[i]),
			.up_data  (div_data[i]),
			.dn_valid (div_valid[i+1]),
			.dn_ready (div_ready[i+1]),
			.dn_data  (div_data[i+1])
		);
	end

	// side angle runs the other way around the tube
	assign phi_angle = '0 - div_data[DS].side.q;

	always_comb begin
		cord_data[0].psi  = tvg_pkg::cord_init(div_data[DS].ring.q);
		cord_data[0].phi  = tvg_pkg::cord_init(phi_angle);
		cord_data[0].meta = div_data[DS].meta;
	end

	assign cord_valid[0] = div_valid[DS];
	assign div_ready[DS] = cord_ready[0];

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		tvg_cordic_cell #(
			.STEP (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cord_valid[i]),
			.up_ready (cord_ready[i]),
			.up_data  (cord_data[i]),
			.dn_valid (cord_valid[i+1]),
			.dn_ready (cord_ready[i+1]),
			.dn_data  (cord_data[i+1])
		);
	end

	tvg_math u_math (
		.clk              (clk),
		.arst_n           (arst_n),
		.inner_radius     (inner_q),
		.outer_radius     (outer_q),
		.side_seg         (ns),
		.up_valid         (cord_valid[CS]),
		.up_ready         (cord_ready[CS]),
		.up_data          (cord_data[CS]),
		.dn_valid         (out_valid),
		.dn_ready         (out_ready),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.norm_x           (norm_x),
		.norm_y           (norm_y),
		.norm_z           (norm_z),
		.vertex_index     (vertex_index),
		.quad_valid       (quad_valid),
		.corner_next_side (corner_next_side),
		.corner_diagonal  (corner_diagonal),
		.corner_next_ring (corner_next_ring)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/tvg_div_cell.sv -----
`default_nettype none
module tvg_div_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [tvg_pkg::SEG_W-1:0]   ring_seg,
	input  wire logic [tvg_pkg::SEG_W-1:0]   side_seg,
	input  wire logic                        up_valid,
	output logic                             up_ready,
	input  wire tvg_pkg::div_t               up_data,
	output logic                             dn_valid,
	input  wire logic                        dn_ready,
	output tvg_pkg::div_t                    dn_data
);

	// one quotient bit of a restoring long division
	function automatic tvg_pkg::div_lane_t step(input tvg_pkg::div_lane_t l,
		input logic [tvg_pkg::SEG_W-1:0] seg);
		logic [tvg_pkg::SEG_W:0] trial;
		tvg_pkg::div_lane_t r;
		trial = {l.rem, l.num[tvg_pkg::IDX_W-1]};
		r.num = {l.num[tvg_pkg::IDX_W-2:0], 1'b0};
		if (trial >= {1'b0, seg}) begin
			r.rem = tvg_pkg::SEG_W'(trial - {1'b0, seg});
			r.q   = {l.q[tvg_pkg::ANGLE_BITS-2:0], 1'b1};
		end else begin
			r.rem = trial[tvg_pkg::SEG_W-1:0];
			r.q   = {l.q[tvg_pkg::ANGLE_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	logic          valid_q;
	tvg_pkg::div_t data_q;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q.ring <= step(up_data.ring, ring_seg);
			data_q.side <= step(up_data.side, side_seg);
			data_q.meta <= up_data.meta;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tvg_cordic_cell.sv -----
`default_nettype none
module tvg_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire tvg_pkg::cord_t  up_data,
	output logic                 dn_valid,
	input  wire logic            dn_ready,
	output tvg_pkg::cord_t       dn_data
);

	function automatic tvg_pkg::cord_lane_t rotate(input tvg_pkg::cord_lane_t l);
		logic signed [tvg_pkg::CW-1:0] dx;
		logic signed [tvg_pkg::CW-1:0] dy;
		tvg_pkg::cord_lane_t r;
		dx = l.y >>> STEP;
		dy = l.x >>> STEP;
		r.quad = l.quad;
		if (!l.z[tvg_pkg::CW-1]) begin
			r.x = l.x - dx;
			r.y = l.y + dy;
			r.z = l.z - tvg_pkg::ATAN_TURNS[STEP];
		end else begin
			r.x = l.x + dx;
			r.y = l.y - dy;
			r.z = l.z + tvg_pkg::ATAN_TURNS[STEP];
		end
		return r;
	endfunction

	logic           valid_q;
	tvg_pkg::cord_t data_q;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q.psi  <= rotate(up_data.psi);
			data_q.phi  <= rotate(up_data.phi);
			data_q.meta <= up_data.meta;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tvg_math.sv -----
`default_nettype none
module tvg_math (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [tvg_pkg::RAD_W-1:0]    inner_radius,
	input  wire logic [tvg_pkg::RAD_W-1:0]    outer_radius,
	input  wire logic [tvg_pkg::SEG_W-1:0]    side_seg,
	input  wire logic                         up_valid,
	output logic                              up_ready,
	input  wire tvg_pkg::cord_t               up_data,
	output logic                              dn_valid,
	input  wire logic                         dn_ready,
	output logic signed [17:0]                pos_x,
	output logic signed [17:0]                pos_y,
	output logic signed [17:0]                pos_z,
	output logic signed [15:0]                norm_x,
	output logic signed [15:0]                norm_y,
	output logic signed [15:0]                norm_z,
	output logic [tvg_pkg::VIDX_W-1:0]        vertex_index,
	output logic                              quad_valid,
	output logic [tvg_pkg::VIDX_W-1:0]        corner_next_side,
	output logic [tvg_pkg::VIDX_W-1:0]        corner_diagonal,
	output logic [tvg_pkg::VIDX_W-1:0]        corner_next_ring
);

	// fold the quadrant back in: returns {cos, sin}
	function automatic logic [31:0] trig(input tvg_pkg::cord_lane_t l);
		logic signed [15:0] cx;
		logic signed [15:0] sy;
		logic [31:0] r;
		cx = tvg_pkg::q14_of(l.x);
		sy = tvg_pkg::q14_of(l.y);
		unique case (l.quad)
			2'd0: r = {cx, sy};
			2'd1: r = {-sy, cx};
			2'd2: r = {-cx, -sy};
			2'd3: r = {sy, -cx};
			default: r = {cx, sy};
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] norm_of(input logic signed [31:0] p);
		logic signed [31:0] r;
		r = (p + 32'sd8192) >>> 14;
		if (r > 32'sd16384) begin
			return 16'sd16384;
		end else if (r < -32'sd16384) begin
			return -16'sd16384;
		end
		return signed'(r[15:0]);
	endfunction

	function automatic logic signed [17:0] pos_of(input logic signed [48:0] p);
		logic signed [48:0] r;
		r = (p + 49'sd134217728) >>> 28;
		if (r > 49'sd131071) begin
			return 18'sd131071;
		end else if (r < -49'sd131072) begin
			return -18'sd131072;
		end
		return signed'(r[17:0]);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [31:0]              psi_cs;
	logic [31:0]              phi_cs;
	logic signed [15:0]       cpsi_s1, spsi_s1, cphi_s1, sphi_s1;
	tvg_pkg::meta_t           meta_s1;

	logic signed [32:0]       t_s2;
	logic signed [32:0]       pzp_s2;
	logic signed [31:0]       nxp_s2, nyp_s2;
	logic signed [15:0]       cpsi_s2, spsi_s2, sphi_s2;
	tvg_pkg::meta_t           meta_s2;

	logic signed [48:0]       pxp_s3, pyp_s3;
	logic signed [32:0]       pz_round;
	logic signed [17:0]       pz_s3;
	logic signed [15:0]       nx_s3, ny_s3, nz_s3;
	tvg_pkg::meta_t           meta_s3;

	logic signed [17:0]       px_s4, py_s4, pz_s4;
	logic signed [15:0]       nx_s4, ny_s4, nz_s4;
	tvg_pkg::meta_t           meta_s4;

	assign rdy4     = !v_s4 || dn_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign up_ready = rdy1;
	assign dn_valid = v_s4;

	assign psi_cs   = trig(up_data.psi);
	assign phi_cs   = trig(up_data.phi);
	assign pz_round = (pzp_s2 + 33'sd8192) >>> 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= up_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_valid) begin
			cpsi_s1 <= signed'(psi_cs[31:16]);
			spsi_s1 <= signed'(psi_cs[15:0]);
			cphi_s1 <= signed'(phi_cs[31:16]);
			sphi_s1 <= signed'(phi_cs[15:0]);
			meta_s1 <= up_data.meta;
		end
		if (rdy2 && v_s1) begin
			t_s2    <= signed'({3'b000, outer_radius, 14'b0})
				+ signed'({1'b0, inner_radius}) * cphi_s1;
			pzp_s2  <= signed'({1'b0, inner_radius}) * sphi_s1;
			nxp_s2  <= cpsi_s1 * cphi_s1;
			nyp_s2  <= spsi_s1 * cphi_s1;
			cpsi_s2 <= cpsi_s1;
			spsi_s2 <= spsi_s1;
			sphi_s2 <= sphi_s1;
			meta_s2 <= meta_s1;
		end
		if (rdy3 && v_s2) begin
			pxp_s3  <= t_s2 * cpsi_s2;
			pyp_s3  <= t_s2 * spsi_s2;
			pz_s3   <= pz_round[17:0];
			nx_s3   <= norm_of(nxp_s2);
			ny_s3   <= norm_of(nyp_s2);
			nz_s3   <= sphi_s2;
			meta_s3 <= meta_s2;
		end
		if (rdy4 && v_s3) begin
			px_s4   <= pos_of(pxp_s3);
			py_s4   <= pos_of(pyp_s3);
			pz_s4   <= pz_s3;
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			nz_s4   <= nz_s3;
			meta_s4 <= meta_s3;
		end
	end

	assign pos_x        = px_s4;
	assign pos_y        = py_s4;
	assign pos_z        = pz_s4;
	assign norm_x       = nx_s4;
	assign norm_y       = ny_s4;
	assign norm_z       = nz_s4;
	assign vertex_index = meta_s4.vidx;
	assign quad_valid   = meta_s4.quad;

	// corner indices wrap at the index width; drop them for points off the quad grid
	always_comb begin
		if (meta_s4.quad) begin
			corner_next_side = meta_s4.vidx + tvg_pkg::VIDX_W'(1);
			corner_diagonal  = meta_s4.vidx + tvg_pkg::VIDX_W'(side_seg) + tvg_pkg::VIDX_W'(2);
			corner_next_ring = meta_s4.vidx + tvg_pkg::VIDX_W'(side_seg) + tvg_pkg::VIDX_W'(1);
		end else begin
			corner_next_side = '0;
			corner_diagonal  = '0;
			corner_next_ring = '0;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tvg_checker.sv -----
`default_nettype none
module tvg_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [17:0] pos_x,
	input wire logic signed [15:0] norm_x,
	input wire logic signed [15:0] norm_y,
	input wire logic [16:0]        vertex_index,
	input wire logic               quad_valid,
	input wire logic [16:0]        corner_next_side,
	input wire logic [16:0]        corner_diagonal,
	input wire logic [16:0]        corner_next_ring
);

	// hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(vertex_index))
		else $error("output transaction changed while stalled");

	a_no_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !quad_valid |->
			corner_next_side == 17'd0 && corner_diagonal == 17'd0 && corner_next_ring == 17'd0)
		else $error("corners set on a point without a quad");

	a_next_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && quad_valid |-> corner_next_side == vertex_index + 17'd1)
		else $error("next side corner does not follow vertex index");

	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && quad_valid |-> corner_diagonal == corner_next_ring + 17'd1)
		else $error("diagonal corner does not follow next ring corner");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> norm_x <= 16'sd16384 && norm_x >= -16'sd16384
			&& norm_y <= 16'sd16384 && norm_y >= -16'sd16384)
		else $error("normal component out of range");

endmodule

bind torus_vertex_generator tvg_checker u_tvg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.pos_x            (pos_x),
	.norm_x           (norm_x),
	.norm_y           (norm_y),
	.vertex_index     (vertex_index),
	.quad_valid       (quad_valid),
	.corner_next_side (corner_next_side),
	.corner_diagonal  (corner_diagonal),
	.corner_next_ring (corner_next_ring)
);
`default_nettype wire
